/* src/utf8d_pkg.sv */
// utf8d_pkg: shared types and byte-class constants of the utf-8 stream decoder
package utf8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned REM_W  = 2;

  // byte class masks and match values
  localparam logic [BYTE_W-1:0] MASK_ASCII = 8'h80;
  localparam logic [BYTE_W-1:0] MASK_2B    = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_3B    = 8'hF0;
  localparam logic [BYTE_W-1:0] MASK_4B    = 8'hF8;
  localparam logic [BYTE_W-1:0] MASK_CONT  = 8'hC0;
  localparam logic [BYTE_W-1:0] MATCH_CONT = 8'h80;
  localparam logic [BYTE_W-1:0] MATCH_2B   = 8'hC0;
  localparam logic [BYTE_W-1:0] MATCH_3B   = 8'hE0;
  localparam logic [BYTE_W-1:0] MATCH_4B   = 8'hF0;

  // sequence lengths
  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_1B   = 3'd1;
  localparam logic [LEN_W-1:0] LEN_2B   = 3'd2;
  localparam logic [LEN_W-1:0] LEN_3B   = 3'd3;
  localparam logic [LEN_W-1:0] LEN_4B   = 3'd4;

  typedef struct packed {
    logic             valid;
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] sequence_length;
  } result_t;

endpackage

/* src/utf8d_in_stage.sv */
// utf8d_in_stage: input register holding one byte item ahead of the decoder
module utf8d_in_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [utf8d_pkg::BYTE_W-1:0]   in_byte,
  input  logic                           advance,
  output logic                           hold_valid,
  output logic [utf8d_pkg::BYTE_W-1:0]   hold_byte
);

  logic                         valid_r;
  logic                         valid_nxt;
  logic [utf8d_pkg::BYTE_W-1:0] byte_r;
  logic                         take;

  assign in_stall   = valid_r & ~advance;
  assign take       = in_valid & ~in_stall;
  assign valid_nxt  = take | (valid_r & ~advance);
  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_byte;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r |-> !in_stall) else $error("stall raised with empty input register");

  a_full_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> valid_r) else $error("accepted item not held");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !advance) |=> (valid_r && $stable(byte_r)))
    else $error("held item lost or changed");

endmodule

/* src/utf8d_decode.sv */
// utf8d_decode: sequence state registers and byte decode logic
module utf8d_decode (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic [utf8d_pkg::BYTE_W-1:0] byte_in,
  output utf8d_pkg::result_t           res
);

  logic [utf8d_pkg::REM_W-1:0] rem_r, rem_nxt;
  logic [utf8d_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [utf8d_pkg::CP_W-1:0]  part_r, part_nxt;
  logic                        is_cont;

  assign is_cont = (byte_in & utf8d_pkg::MASK_CONT) == utf8d_pkg::MATCH_CONT;

  always_comb begin
    rem_nxt  = rem_r;
    len_nxt  = len_r;
    part_nxt = part_r;
    res      = '0;
    if ((rem_r != '0) && is_cont) begin
      part_nxt = {part_r[utf8d_pkg::CP_W-7:0], byte_in[5:0]};
      rem_nxt  = rem_r - 2'd1;
      if (rem_r == 2'd1) begin
        res.valid           = 1'b1;
        res.code_point      = part_nxt;
        res.sequence_length = len_r;
        len_nxt             = utf8d_pkg::LEN_NONE;
      end
    end else begin
      // broken or no open sequence: byte is examined as a lead
      rem_nxt = '0;
      len_nxt = utf8d_pkg::LEN_NONE;
      if ((byte_in & utf8d_pkg::MASK_ASCII) == '0) begin
        res.valid           = 1'b1;
        res.code_point      = {{(utf8d_pkg::CP_W-utf8d_pkg::BYTE_W){1'b0}}, byte_in};
        res.sequence_length = utf8d_pkg::LEN_1B;
      end else if ((byte_in & utf8d_pkg::MASK_2B) == utf8d_pkg::MATCH_2B) begin
        part_nxt = {{(utf8d_pkg::CP_W-5){1'b0}}, byte_in[4:0]};
        rem_nxt  = 2'd1;
        len_nxt  = utf8d_pkg::LEN_2B;
      end else if ((byte_in & utf8d_pkg::MASK_3B) == utf8d_pkg::MATCH_3B) begin
        part_nxt = {{(utf8d_pkg::CP_W-4){1'b0}}, byte_in[3:0]};
        rem_nxt  = 2'd2;
        len_nxt  = utf8d_pkg::LEN_3B;
      end else if ((byte_in & utf8d_pkg::MASK_4B) == utf8d_pkg::MATCH_4B) begin
        part_nxt = {{(utf8d_pkg::CP_W-3){1'b0}}, byte_in[2:0]};
        rem_nxt  = 2'd3;
        len_nxt  = utf8d_pkg::LEN_4B;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      len_r <= utf8d_pkg::LEN_NONE;
    end else if (fire) begin
      rem_r <= rem_nxt;
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      part_r <= part_nxt;
    end
  end

  a_open_matches_len: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r == '0) == (len_r == utf8d_pkg::LEN_NONE))
    else $error("remaining count and open length disagree");

  a_rem_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r != '0) |-> ({1'b0, rem_r} < len_r))
    else $error("more bytes remaining than sequence length");

  a_res_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.valid) |-> (res.sequence_length != utf8d_pkg::LEN_NONE &&
                             res.sequence_length <= utf8d_pkg::LEN_4B))
    else $error("result with bad sequence length");

endmodule

/* src/utf8_stream_decoder_core.sv */
// utf8_stream_decoder_core: top level of the byte-serial utf-8 decoder
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  in_byte (8)
//  out_     output     out_valid/out_stall  out_code_point (21), out_sequence_length (3)
//
//  one byte item accepted per cycle while in_stall is low; the last byte of a sequence is
//  held in the input register, decoded and loaded into the result register, which drives
//  the outputs; these two registers sit around the combinational decode logic
//  synchronous active-low reset clears the open sequence and both valid flags
//  out_stall backs up into in_stall only when both registers are full
module utf8_stream_decoder_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [utf8d_pkg::BYTE_W-1:0]        in_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [utf8d_pkg::CP_W-1:0]          out_code_point,
  output logic [utf8d_pkg::LEN_W-1:0]         out_sequence_length
);

  logic                         hold_valid;
  logic [utf8d_pkg::BYTE_W-1:0] hold_byte;
  logic                         advance;
  logic                         fire;
  utf8d_pkg::result_t           res;

  logic                         out_valid_r, out_valid_nxt;
  logic [utf8d_pkg::CP_W-1:0]   cp_r;
  logic [utf8d_pkg::LEN_W-1:0]  len_r;
  logic                         load;

  assign advance = ~out_valid_r | ~out_stall;
  assign fire    = hold_valid & advance;
  assign load    = fire & res.valid;

  utf8d_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  utf8d_decode u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .byte_in (hold_byte),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r  <= res.code_point;
      len_r <= res.sequence_length;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_code_point      = cp_r;
  assign out_sequence_length = len_r;

  a_no_fire_while_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !fire)
    else $error("decode fired while result register blocked");

  a_result_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r) else $error("result item lost");

  a_stall_needs_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && hold_valid))
    else $error("input stalled without back-pressure");

endmodule
